// ===== rtl/prra_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and sizes for the priority round-robin run arbiter.
// Used by prra_table, prra_scan and the top level; depends on nothing.
package prra_pkg;

    localparam int NUM_MEMBERS = 16;
    localparam int IDX_W       = $clog2(NUM_MEMBERS);
    localparam int KEY_W       = 32;
    localparam int PRIO_W      = 16;
    localparam int ORDER_W     = 16;

    // Caller ids below this limit address a slot.
    localparam logic [7:0] ID_LIMIT = 8'(NUM_MEMBERS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_MEMBERS - 1);

    // Request types.
    localparam logic [1:0] REQ_JOIN    = 2'd0;
    localparam logic [1:0] REQ_LEAVE   = 2'd1;
    localparam logic [1:0] REQ_REQUEST = 2'd2;
    localparam logic [1:0] REQ_RELEASE = 2'd3;

    // Result status codes.
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_BAD  = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    typedef enum logic [1:0] {
        SLOT_IDLE  = 2'd0,
        SLOT_READY = 2'd1,
        SLOT_RUN   = 2'd2
    } slot_st_t;

    // One slot as seen through the table read port.
    typedef struct packed {
        logic                used;
        slot_st_t            state;
        logic [PRIO_W-1:0]   prio;
        logic [ORDER_W-1:0]  order;
    } entry_t;

    // One write command to the slot table.
    typedef struct packed {
        logic                en;
        logic [IDX_W-1:0]    idx;
        logic                wr_used;
        logic                used;
        logic                wr_state;
        slot_st_t            state;
        logic                wr_prio;
        logic [PRIO_W-1:0]   prio;
        logic                wr_order;
        logic [ORDER_W-1:0]  order;
        logic                clr_order;
    } tbl_wr_t;

    // Running results of one pass over the table.
    typedef struct packed {
        logic                best_found;
        logic [IDX_W-1:0]    best_idx;
        logic                free_found;
        logic [IDX_W-1:0]    free_idx;
        logic                any_run;
    } scan_res_t;

endpackage

// ===== rtl/priority_round_robin_run_arbiter.sv =====
`timescale 1ns / 1ps
// Single-runner priority arbiter with round-robin aging over a slot table.
// Top level: sequencer, decision logic and result register; uses prra_pkg,
// prra_table and prra_scan.
//
// Each request item is answered by exactly one result item. An accepted item
// walks the slot table one slot per cycle through a single 32-bit key
// comparator. The block accepts the item, reads each slot in turn, then
// decides, then grants and loads the result. s_tready is high only between
// items. The result sits in an output register, so the next item can be
// accepted while it waits; the block stalls at its grant step only if the
// previous result is still not taken. Ties on {priority, order} go to the
// lowest slot index.
module priority_round_robin_run_arbiter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] req_type, [9:2] caller_id, [25:10] priority_req, [31:26] zero
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] status, [5:2] assigned_id, [6] granted, [7] must_wait,
    // [8] woken_valid, [12:9] woken_id, [15:13] zero
    output logic [15:0] m_tdata
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DECIDE = 4'b0100,
        S_GRANT  = 4'b1000
    } seq_st_t;

    seq_st_t                          state_reg, state_next;
    logic [prra_pkg::IDX_W-1:0]       idx_reg;
    logic [1:0]                       req_reg;
    logic [7:0]                       id_reg;
    logic [prra_pkg::PRIO_W-1:0]      in_prio_reg;
    logic                             caller_used_reg;
    prra_pkg::slot_st_t               caller_state_reg;
    logic [prra_pkg::ORDER_W-1:0]     cnt_reg;
    logic                             grant_do_reg, grant_do_next;
    logic [prra_pkg::IDX_W-1:0]       grant_idx_reg, grant_idx_next;
    logic [1:0]                       res_status_reg, res_status_next;
    logic [3:0]                       res_assigned_reg, res_assigned_next;
    logic                             res_granted_reg, res_granted_next;
    logic                             res_wait_reg, res_wait_next;
    logic                             res_wvalid_reg, res_wvalid_next;
    logic [3:0]                       res_wid_reg, res_wid_next;
    logic                             m_valid_reg;
    logic [15:0]                      m_data_reg;

    logic                             accept;
    logic                             advance;
    logic                             id_in_range;
    logic                             id_ok;
    logic                             caller_hit;
    logic [prra_pkg::IDX_W-1:0]       caller_idx;
    logic [prra_pkg::ORDER_W-1:0]     cnt_inc;
    prra_pkg::tbl_wr_t                decide_wr, grant_wr, tbl_wr;
    prra_pkg::entry_t                 rd_entry;
    prra_pkg::scan_res_t              scan;
    logic [prra_pkg::NUM_MEMBERS-1:0] run_vec;

    assign s_tready    = (state_reg == S_IDLE);
    assign accept      = s_tvalid && s_tready;
    assign advance     = !m_valid_reg || m_tready;
    assign id_in_range = (id_reg < prra_pkg::ID_LIMIT);
    assign id_ok       = id_in_range && caller_used_reg;
    assign caller_idx  = id_reg[prra_pkg::IDX_W-1:0];
    assign caller_hit  = id_in_range && (caller_idx == idx_reg);
    assign cnt_inc     = cnt_reg + 1'b1;

    prra_table u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr       (tbl_wr),
        .rd_idx   (idx_reg),
        .rd_entry (rd_entry),
        .run_vec  (run_vec)
    );

    // A releasing caller is counted as idle while the next runner is chosen.
    prra_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (state_reg == S_SCAN),
        .first   (idx_reg == '0),
        .exclude ((req_reg == prra_pkg::REQ_RELEASE) && caller_hit),
        .idx     (idx_reg),
        .entry   (rd_entry),
        .res     (scan)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (idx_reg == prra_pkg::LAST_IDX) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                state_next = S_GRANT;
            end
            S_GRANT: begin
                if (advance) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Decision on the scan results, plus the write for the caller or new slot.
    always_comb begin
        decide_wr         = '0;
        decide_wr.idx     = caller_idx;
        grant_do_next     = 1'b0;
        grant_idx_next    = caller_idx;
        res_status_next   = prra_pkg::STATUS_OK;
        res_assigned_next = id_reg[3:0];
        res_granted_next  = 1'b0;
        res_wait_next     = 1'b0;
        res_wvalid_next   = 1'b0;
        res_wid_next      = '0;
        case (req_reg)
            prra_pkg::REQ_JOIN: begin
                if (scan.free_found) begin
                    decide_wr.en       = 1'b1;
                    decide_wr.idx      = scan.free_idx;
                    decide_wr.wr_used  = 1'b1;
                    decide_wr.used     = 1'b1;
                    decide_wr.wr_state = 1'b1;
                    decide_wr.state    = prra_pkg::SLOT_IDLE;
                    decide_wr.wr_prio  = 1'b1;
                    decide_wr.prio     = in_prio_reg;
                    decide_wr.wr_order = 1'b1;
                    decide_wr.order    = cnt_reg;
                    res_assigned_next  = 4'(scan.free_idx);
                end else begin
                    res_status_next = prra_pkg::STATUS_FULL;
                end
            end
            prra_pkg::REQ_LEAVE: begin
                if (id_ok) begin
                    decide_wr.en      = 1'b1;
                    decide_wr.wr_used = 1'b1;
                    decide_wr.used    = 1'b0;
                end else begin
                    res_status_next = prra_pkg::STATUS_BAD;
                end
            end
            prra_pkg::REQ_REQUEST: begin
                if (!id_ok || (caller_state_reg == prra_pkg::SLOT_READY)) begin
                    res_status_next = prra_pkg::STATUS_BAD;
                end else if (caller_state_reg == prra_pkg::SLOT_RUN) begin
                    if (!scan.best_found || (scan.best_idx == caller_idx)) begin
                        res_granted_next = 1'b1;
                    end else begin
                        decide_wr.en       = 1'b1;
                        decide_wr.wr_state = 1'b1;
                        decide_wr.state    = prra_pkg::SLOT_READY;
                        res_wait_next      = 1'b1;
                        grant_do_next      = 1'b1;
                        grant_idx_next     = scan.best_idx;
                        res_wvalid_next    = 1'b1;
                        res_wid_next       = 4'(scan.best_idx);
                    end
                end else if (scan.any_run) begin
                    decide_wr.en       = 1'b1;
                    decide_wr.wr_state = 1'b1;
                    decide_wr.state    = prra_pkg::SLOT_READY;
                    res_wait_next      = 1'b1;
                end else begin
                    grant_do_next    = 1'b1;
                    res_granted_next = 1'b1;
                end
            end
            prra_pkg::REQ_RELEASE: begin
                if (!id_ok || (caller_state_reg != prra_pkg::SLOT_RUN)) begin
                    res_status_next = prra_pkg::STATUS_BAD;
                end else begin
                    decide_wr.en       = 1'b1;
                    decide_wr.wr_state = 1'b1;
                    decide_wr.state    = prra_pkg::SLOT_IDLE;
                    if (scan.best_found) begin
                        grant_do_next   = 1'b1;
                        grant_idx_next  = scan.best_idx;
                        res_wvalid_next = 1'b1;
                        res_wid_next    = 4'(scan.best_idx);
                    end
                end
            end
            default: begin
                res_status_next = prra_pkg::STATUS_BAD;
            end
        endcase
    end

    // The grant write; on counter wrap all used orders clear before the
    // winner takes the new count.
    always_comb begin
        grant_wr           = '0;
        grant_wr.en        = 1'b1;
        grant_wr.idx       = grant_idx_reg;
        grant_wr.wr_state  = 1'b1;
        grant_wr.state     = prra_pkg::SLOT_RUN;
        grant_wr.wr_order  = 1'b1;
        grant_wr.order     = cnt_inc;
        grant_wr.clr_order = (cnt_inc == '0);
    end

    always_comb begin
        tbl_wr = '0;
        if (state_reg == S_DECIDE) begin
            tbl_wr = decide_wr;
        end else if ((state_reg == S_GRANT) && advance && grant_do_reg) begin
            tbl_wr = grant_wr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            idx_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                idx_reg <= '0;
            end else if ((state_reg == S_SCAN) && (idx_reg != prra_pkg::LAST_IDX)) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if ((state_reg == S_GRANT) && advance) begin
                m_valid_reg <= 1'b1;
                if (grant_do_reg) begin
                    cnt_reg <= cnt_inc;
                end
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg         <= s_tdata[1:0];
            id_reg          <= s_tdata[9:2];
            in_prio_reg     <= s_tdata[25:10];
            caller_used_reg <= 1'b0;
        end else if ((state_reg == S_SCAN) && caller_hit) begin
            caller_used_reg  <= rd_entry.used;
            caller_state_reg <= rd_entry.state;
        end
        if (state_reg == S_DECIDE) begin
            grant_do_reg     <= grant_do_next;
            grant_idx_reg    <= grant_idx_next;
            res_status_reg   <= res_status_next;
            res_assigned_reg <= res_assigned_next;
            res_granted_reg  <= res_granted_next;
            res_wait_reg     <= res_wait_next;
            res_wvalid_reg   <= res_wvalid_next;
            res_wid_reg      <= res_wid_next;
        end
        if ((state_reg == S_GRANT) && advance) begin
            m_data_reg <= {3'b000, res_wid_reg, res_wvalid_reg, res_wait_reg,
                           res_granted_reg, res_assigned_reg, res_status_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // At most one used slot is ever running.
    a_single_runner: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(run_vec) <= 1)
        else $error("more than one used slot in RUN");

    // A rejected item reports no grant, no wait and no woken runner.
    a_reject_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[1:0] != prra_pkg::STATUS_OK))
            |-> (m_tdata[8:6] == 3'b000))
        else $error("rejected item reports a grant or a wait");

    // The caller cannot be both running and waiting.
    a_grant_xor_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[6] && m_tdata[7]))
        else $error("granted and must_wait both set");

    // A result is never loaded in the cycle right after an item is accepted.
    a_min_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !(state_reg == S_GRANT))
        else $error("sequencer skipped the slot scan");

endmodule

// ===== rtl/prra_table.sv =====
`timescale 1ns / 1ps
// Slot table of the arbiter: used bits, slot states and the two key halves.
// One read port at a sequencer index and one write command per cycle; uses prra_pkg.
module prra_table (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  prra_pkg::tbl_wr_t                   wr,
    input  logic [prra_pkg::IDX_W-1:0]          rd_idx,
    output prra_pkg::entry_t                    rd_entry,
    output logic [prra_pkg::NUM_MEMBERS-1:0]    run_vec
);

    logic [prra_pkg::NUM_MEMBERS-1:0] used_reg;
    prra_pkg::slot_st_t               state_reg [prra_pkg::NUM_MEMBERS];
    logic [prra_pkg::PRIO_W-1:0]      prio_reg  [prra_pkg::NUM_MEMBERS];
    logic [prra_pkg::ORDER_W-1:0]     order_reg [prra_pkg::NUM_MEMBERS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
            for (int i = 0; i < prra_pkg::NUM_MEMBERS; i++) begin
                state_reg[i] <= prra_pkg::SLOT_IDLE;
            end
        end else if (wr.en) begin
            if (wr.wr_used) begin
                used_reg[wr.idx] <= wr.used;
            end
            if (wr.wr_state) begin
                state_reg[wr.idx] <= wr.state;
            end
        end
    end

    // Key fields of unused slots are never looked at, so they need no reset.
    always_ff @(posedge aclk) begin
        if (wr.clr_order) begin
            for (int i = 0; i < prra_pkg::NUM_MEMBERS; i++) begin
                if (used_reg[i]) begin
                    order_reg[i] <= '0;
                end
            end
        end
        if (wr.en && wr.wr_prio) begin
            prio_reg[wr.idx] <= wr.prio;
        end
        if (wr.en && wr.wr_order) begin
            order_reg[wr.idx] <= wr.order;
        end
    end

    always_comb begin
        rd_entry.used  = used_reg[rd_idx];
        rd_entry.state = state_reg[rd_idx];
        rd_entry.prio  = prio_reg[rd_idx];
        rd_entry.order = order_reg[rd_idx];
        for (int i = 0; i < prra_pkg::NUM_MEMBERS; i++) begin
            run_vec[i] = used_reg[i] && (state_reg[i] == prra_pkg::SLOT_RUN);
        end
    end

endmodule

// ===== rtl/prra_scan.sv =====
`timescale 1ns / 1ps
// Shared key compare unit: takes one slot per cycle while step is high and
// keeps the best non-idle slot, the lowest free slot and a runner flag; uses prra_pkg.
module prra_scan (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic                          first,
    input  logic                          exclude,
    input  logic [prra_pkg::IDX_W-1:0]    idx,
    input  prra_pkg::entry_t              entry,
    output prra_pkg::scan_res_t           res
);

    prra_pkg::scan_res_t           res_reg;
    prra_pkg::scan_res_t           res_next;
    logic [prra_pkg::KEY_W-1:0]    best_key_reg;
    logic [prra_pkg::KEY_W-1:0]    best_key_next;
    prra_pkg::scan_res_t           prev;
    logic [prra_pkg::KEY_W-1:0]    cand_key;
    logic                          cand;

    always_comb begin
        prev     = first ? '0 : res_reg;
        cand_key = {entry.prio, entry.order};
        cand     = entry.used && (entry.state != prra_pkg::SLOT_IDLE) && !exclude;

        res_next      = prev;
        best_key_next = best_key_reg;
        // Strict less-than keeps the lowest index among equal keys.
        if (cand && (!prev.best_found || (cand_key < best_key_reg))) begin
            res_next.best_found = 1'b1;
            res_next.best_idx   = idx;
            best_key_next       = cand_key;
        end
        if (!entry.used && !prev.free_found) begin
            res_next.free_found = 1'b1;
            res_next.free_idx   = idx;
        end
        if (entry.used && (entry.state == prra_pkg::SLOT_RUN) && !exclude) begin
            res_next.any_run = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_reg <= '0;
        end else if (step) begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            best_key_reg <= best_key_next;
        end
    end

    assign res = res_reg;

endmodule
